/* sv/hwm_pkg.sv */
package hwm_pkg;

  localparam logic [1:0] MODE_CONTENT  = 2'd0;
  localparam logic [1:0] MODE_TAG      = 2'd1;
  localparam logic [1:0] MODE_VERBATIM = 2'd2;

  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
  localparam logic [1:0] QUOTE_SINGLE = 2'd2;

  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam int unsigned NUM_TAGS = 4;

  // pre, script, style, textarea
  localparam logic [7:0] TAG_TEXT [NUM_TAGS][8] = '{
    '{8'h70, 8'h72, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h00, 8'h00},
    '{8'h73, 8'h74, 8'h79, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h74, 8'h65, 8'h78, 8'h74, 8'h61, 8'h72, 8'h65, 8'h61}
  };
  localparam logic [3:0] TAG_LEN [NUM_TAGS] = '{4'd3, 4'd6, 4'd5, 4'd8};

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QIDX_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] parse_mode;
    logic [1:0] quote_kind;
    logic       space_pending;
    logic [7:0] last_emitted;
    logic [3:0] open_match_pos;
    logic [3:0] open_candidates;
    logic       sensitive_armed;
    logic [1:0] sensitive_tag_id;
    logic [3:0] close_match_pos;
  } state_t;

  localparam state_t STATE_RESET = '{
    parse_mode:       MODE_CONTENT,
    quote_kind:       QUOTE_NONE,
    space_pending:    1'b0,
    last_emitted:     8'h00,
    open_match_pos:   4'd0,
    open_candidates:  4'd0,
    sensitive_armed:  1'b0,
    sensitive_tag_id: 2'd0,
    close_match_pos:  4'd0
  };

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5a)) ? (b + 8'h20) : b;
  endfunction

endpackage

/* sv/hwm_core.sv */
module hwm_core import hwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic [1:0] push_cnt_o,
  output res_t [1:0] push_res_o
);

  state_t     state_q, state_d;
  state_t     s;
  logic [1:0] cnt;
  logic [7:0] r0, r1;
  logic [7:0] b;
  logic [7:0] prev;
  logic [3:0] k;
  logic [3:0] keep;
  logic       hit;
  logic [1:0] hit_id;
  logic [3:0] p;
  logic [3:0] len;
  logic [3:0] restart;
  logic [3:0] pm2;

  always_comb begin
    s       = state_q;
    cnt     = 2'd0;
    r0      = 8'h00;
    r1      = 8'h00;
    b       = in_byte_i;
    prev    = state_q.last_emitted;
    k       = state_q.open_match_pos - 4'd1;
    keep    = 4'd0;
    hit     = 1'b0;
    hit_id  = 2'd0;
    p       = state_q.close_match_pos;
    len     = TAG_LEN[state_q.sensitive_tag_id];
    restart = (b == CH_LT) ? 4'd1 : 4'd0;
    pm2     = p - 4'd2;

    if (state_q.parse_mode == MODE_TAG) begin
      if (state_q.open_match_pos != 4'd0) begin
        for (int t = 0; t < NUM_TAGS; t++) begin
          if (state_q.open_candidates[t]) begin
            if (TAG_LEN[t] == k) begin
              if ((b == CH_GT) || (b == CH_SLASH) || is_ws(b)) begin
                hit    = 1'b1;
                hit_id = 2'(t);
              end
            end else if ((k < TAG_LEN[t]) && (fold(b) == TAG_TEXT[t][k[2:0]])) begin
              keep[t] = 1'b1;
            end
          end
        end
        if (hit) begin
          s.sensitive_armed  = 1'b1;
          s.sensitive_tag_id = hit_id;
        end
        if (hit || (keep == 4'd0)) begin
          s.open_match_pos  = 4'd0;
          s.open_candidates = 4'd0;
        end else begin
          s.open_match_pos  = state_q.open_match_pos + 4'd1;
          s.open_candidates = keep;
        end
      end
      r0             = b;
      cnt            = 2'd1;
      s.last_emitted = b;
      if (state_q.quote_kind != QUOTE_NONE) begin
        if (((state_q.quote_kind == QUOTE_DOUBLE) && (b == CH_DQ)) ||
            ((state_q.quote_kind == QUOTE_SINGLE) && (b == CH_SQ))) begin
          s.quote_kind = QUOTE_NONE;
        end
      end else if (b == CH_GT) begin
        s.parse_mode      = (s.sensitive_armed && (prev != CH_SLASH)) ? MODE_VERBATIM
                                                                      : MODE_CONTENT;
        s.sensitive_armed = 1'b0;
        s.open_match_pos  = 4'd0;
        s.open_candidates = 4'd0;
        s.close_match_pos = 4'd0;
      end else if (b == CH_DQ) begin
        s.quote_kind = QUOTE_DOUBLE;
      end else if (b == CH_SQ) begin
        s.quote_kind = QUOTE_SINGLE;
      end
    end else if (state_q.parse_mode == MODE_VERBATIM) begin
      r0             = b;
      cnt            = 2'd1;
      s.last_emitted = b;
      if (p == 4'd0) begin
        s.close_match_pos = restart;
      end else if (p == 4'd1) begin
        s.close_match_pos = (b == CH_SLASH) ? 4'd2 : restart;
      end else if (p < (len + 4'd2)) begin
        s.close_match_pos =
          (fold(b) == TAG_TEXT[state_q.sensitive_tag_id][pm2[2:0]]) ? (p + 4'd1) : restart;
      end else if (p == (len + 4'd2)) begin
        if (b == CH_GT) begin
          s.parse_mode      = MODE_CONTENT;
          s.close_match_pos = 4'd0;
        end else if (is_ws(b)) begin
          s.parse_mode      = MODE_TAG;
          s.quote_kind      = QUOTE_NONE;
          s.sensitive_armed = 1'b0;
          s.open_match_pos  = 4'd0;
          s.open_candidates = 4'd0;
          s.close_match_pos = 4'd0;
        end else begin
          s.close_match_pos = restart;
        end
      end else begin
        s.close_match_pos = restart;
      end
    end else begin
      if (is_ws(b)) begin
        s.space_pending = 1'b1;
        if (in_last_i) begin
          r0             = CH_SPACE;
          cnt            = 2'd1;
          s.last_emitted = CH_SPACE;
        end
      end else begin
        if (state_q.space_pending) begin
          s.space_pending = 1'b0;
          if (!((b == CH_LT) && (state_q.last_emitted == CH_GT))) begin
            r0  = CH_SPACE;
            cnt = 2'd1;
          end
        end
        if (cnt == 2'd0) begin
          r0 = b;
        end else begin
          r1 = b;
        end
        cnt            = cnt + 2'd1;
        s.last_emitted = b;
        if (b == CH_LT) begin
          s.parse_mode      = MODE_TAG;
          s.quote_kind      = QUOTE_NONE;
          s.sensitive_armed = 1'b0;
          s.open_match_pos  = 4'd1;
          s.open_candidates = 4'hf;
        end
      end
    end

    state_d = in_last_i ? STATE_RESET : s;

    push_cnt_o         = accept_i ? cnt : 2'd0;
    push_res_o[0].data = r0;
    push_res_o[0].last = in_last_i && (cnt == 2'd1);
    push_res_o[1].data = r1;
    push_res_o[1].last = in_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/hwm_outq.sv */
module hwm_outq import hwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  push_cnt_i,
  input  res_t [1:0]  push_res_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        out_res_o
);

  localparam logic [QIDX_W:0] CountMax = QIDX_W'(0) + (QIDX_W + 1)'(QDEPTH);

  res_t              mem [QDEPTH];
  logic [QIDX_W-1:0] head_q, head_d;
  logic [QIDX_W-1:0] tail_q, tail_d;
  logic [QIDX_W:0]   count_q, count_d;
  logic              pop;

  assign pop         = (count_q != '0) && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem[head_q];
  assign room_o      = count_q <= (CountMax - (QIDX_W + 1)'(2));

  always_comb begin
    head_d  = pop ? (head_q + QIDX_W'(1)) : head_q;
    tail_d  = tail_q + QIDX_W'(push_cnt_i);
    count_d = count_q + (QIDX_W + 1)'(push_cnt_i) - (QIDX_W + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem[tail_q] <= push_res_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem[tail_q + QIDX_W'(1)] <= push_res_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

/* sv/html_whitespace_minifier.sv */
// an accepted item's results are registered into the result queue and reach the outputs from there
// throughput: one item per cycle while the input is not stalled; two results from one item leave one after the other
// a four-entry result queue decouples the sides; input stalls when fewer than two slots are free
// reset (rst_ni low, asynchronous) clears parser state and empties the result queue
// parser state also returns to its reset values after each item marked last
module html_whitespace_minifier import hwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic       room;
  logic       accept;
  logic [1:0] push_cnt;
  res_t [1:0] push_res;
  res_t       out_res;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  hwm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .push_cnt_o (push_cnt),
    .push_res_o (push_res)
  );

  hwm_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_res_i  (push_res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign out_byte_o = out_res.data;
  assign out_last_o = out_res.last;

endmodule
